// ----- rtl/sbe_pkg.sv -----
`default_nettype none
package sbe_pkg;

  localparam int unsigned StackDepthDef   = 64;
  localparam int unsigned DataWordsDef    = 256;
  localparam int unsigned ProgramWordsDef = 4096;
  localparam int unsigned WordBitsDef     = 32;

  localparam int unsigned CmdBits   = 4;
  localparam int unsigned OpBits    = 32;
  localparam int unsigned PcOutBits = 12;
  localparam int unsigned KindBits  = 3;
  localparam int unsigned ErrBits   = 3;

  typedef enum logic [CmdBits-1:0] {
    CmdAdd = 4'd0, CmdSub = 4'd1, CmdMul = 4'd2, CmdDiv = 4'd3,
    CmdNeg = 4'd4, CmdAssign = 4'd5, CmdRead = 4'd6, CmdNewline = 4'd7,
    CmdWriteint = 4'd8, CmdPush = 4'd9, CmdLoad = 4'd10, CmdJmp = 4'd11,
    CmdJmpz = 4'd12, CmdHalt = 4'd13, CmdBad14 = 4'd14, CmdBad15 = 4'd15
  } cmd_e;

  typedef enum logic [KindBits-1:0] {
    KindNone = 3'd0, KindInt = 3'd1, KindNewline = 3'd2, KindHalted = 3'd3,
    KindError = 3'd4
  } kind_e;

  typedef enum logic [ErrBits-1:0] {
    ErrNone = 3'd0, ErrDivZero = 3'd1, ErrUnknown = 3'd2, ErrStack = 3'd3,
    ErrAddr = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    StIdle, StRead, StMem, StExec, StDiv, StDone
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input transaction
    logic rd_issue;  // stack/memory reads
    logic exec;      // check and decide
    logic div_start;
    logic commit;    // write state, load result
    logic out_take;  // result delivered
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic ready;     // data memory clear finished
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/sbe_ctrl.sv -----
`default_nettype none
module sbe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire sbe_pkg::stat_t stat_i,
  output sbe_pkg::ctrl_t     ctrl_o
);
  import sbe_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // sequencing: capture, stack read, memory read, execute, optional divide, commit
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ov_d    = ov_q;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
      ctrl_o.out_take = 1'b1;
    end
    in_stall_o = (state_q != StIdle) || !stat_i.ready;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && stat_i.ready) begin
          ctrl_o.capture = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        ctrl_o.rd_issue = 1'b1;
        state_d = StMem;
      end
      StMem: begin
        state_d = StExec;
      end
      StExec: begin
        ctrl_o.exec = 1'b1;
        if (stat_i.need_div) begin
          ctrl_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StDone;
        end
      end
      StDiv: begin
        if (stat_i.div_done) state_d = StDone;
      end
      StDone: begin
        if (!ov_d) begin
          ctrl_o.commit = 1'b1;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

// ----- rtl/sbe_div.sv -----
`default_nettype none
module sbe_div #(
  parameter int unsigned WordBits = sbe_pkg::WordBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [WordBits-1:0] num_i,
  input  wire logic [WordBits-1:0] den_i,
  output logic                     done_o,
  output logic [WordBits-1:0]      quo_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);

  logic [CntBits-1:0]  cnt_q;
  logic                busy_q, neg_q;
  logic [WordBits-1:0] rem_q, quo_q, den_q;
  logic [WordBits:0]   trial;

  assign trial = {rem_q, quo_q[WordBits-1]} - {1'b0, den_q};

  // restoring divide on magnitudes, one bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(WordBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[WordBits-1] ^ den_i[WordBits-1];
      quo_q <= num_i[WordBits-1] ? -num_i : num_i;
      den_q <= den_i[WordBits-1] ? -den_i : den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[WordBits]) begin
        rem_q <= trial[WordBits-1:0];
        quo_q <= {quo_q[WordBits-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[WordBits-2:0], quo_q[WordBits-1]};
        quo_q <= {quo_q[WordBits-2:0], 1'b0};
      end
    end
  end

  assign done_o = busy_q && (cnt_q == CntBits'(1)) && !start_i;
  // quotient bit computed this cycle is folded in by caller on the next cycle
  assign quo_o  = neg_q ? -quo_q : quo_q;
endmodule
`default_nettype wire

// ----- rtl/sbe_dpath.sv -----
`default_nettype none
module sbe_dpath #(
  parameter int unsigned StackDepth   = sbe_pkg::StackDepthDef,
  parameter int unsigned DataWords    = sbe_pkg::DataWordsDef,
  parameter int unsigned ProgramWords = sbe_pkg::ProgramWordsDef,
  parameter int unsigned WordBits     = sbe_pkg::WordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sbe_pkg::ctrl_t                ctrl_i,
  output sbe_pkg::stat_t                     stat_o,
  input  wire logic [sbe_pkg::CmdBits-1:0]   command_i,
  input  wire logic signed [sbe_pkg::OpBits-1:0] operand_i,
  output logic [sbe_pkg::PcOutBits-1:0]      next_pc_o,
  output logic [sbe_pkg::KindBits-1:0]       out_kind_o,
  output logic signed [sbe_pkg::OpBits-1:0]  out_value_o,
  output logic [sbe_pkg::ErrBits-1:0]        error_code_o
);
  import sbe_pkg::*;

  localparam int unsigned SpBits = $clog2(StackDepth + 1);
  localparam int unsigned SaBits = $clog2(StackDepth);
  localparam int unsigned DaBits = $clog2(DataWords);
  localparam int unsigned PcBits = $clog2(ProgramWords);
  localparam int unsigned WbBits = $clog2(DataWords + 1);

  logic [WordBits-1:0] stk_mem [StackDepth];
  logic [WordBits-1:0] dat_mem [DataWords];

  cmd_e                cmd_q;
  logic [WordBits-1:0] opw_q, t_q, s_q, dm_q, res_q;
  logic [PcBits-1:0]   pc_q, pcn_q;
  logic [SpBits-1:0]   sp_q, spn_q;
  logic                halted_q, halt_d_q;
  logic [WbBits-1:0]   wipe_q;
  logic                wipe_done;
  kind_e               kind_q;
  err_e                err_q;
  logic [WordBits-1:0] val_q;
  logic                stk_we_q, dat_we_q, use_div_q;
  logic [SaBits-1:0]   stk_wa_q;
  logic [DaBits-1:0]   dat_wa_q;
  logic [WordBits-1:0] dat_wd_q;

  logic [PcOutBits-1:0] npc_o_q;
  kind_e               okind_q;
  err_e                oerr_q;
  logic [OpBits-1:0]   oval_q;

  logic                div_done;
  logic [WordBits-1:0] div_quo;

  // operand sign-extended or truncated to word width
  logic [WordBits-1:0] opw;
  assign opw = WordBits'($signed(operand_i));

  // stack read addresses
  logic [SaBits-1:0] ra_t, ra_s;
  assign ra_t = SaBits'(sp_q - SpBits'(1));
  assign ra_s = SaBits'(sp_q - SpBits'(2));

  // data memory: cleared by a sweep after reset, one word a cycle
  assign wipe_done = (wipe_q == WbBits'(DataWords));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wipe_q <= '0;
    else if (!wipe_done) wipe_q <= wipe_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_e'(command_i);
      opw_q <= opw;
    end
    if (ctrl_i.rd_issue) begin
      t_q <= stk_mem[ra_t];
      s_q <= stk_mem[ra_s];
    end
    if (!wipe_done) dat_mem[DaBits'(wipe_q)] <= '0;
    else if (ctrl_i.commit && dat_we_q) dat_mem[dat_wa_q] <= dat_wd_q;
    if (ctrl_i.commit && stk_we_q) stk_mem[stk_wa_q] <= use_div_q ? div_quo : res_q;
  end

  // data read uses the top of stack after it is registered
  always_ff @(posedge clk_i) begin
    dm_q <= dat_mem[t_q[DaBits-1:0]];
  end

  // address checks
  function automatic logic addr_ok(input logic [WordBits-1:0] w, input int unsigned lim);
    logic [WordBits:0] wl;
    wl = {1'b0, w};
    return !w[WordBits-1] && (wl < (WordBits+1)'(lim));
  endfunction

  // execute decision, registered for commit
  logic [1:0] need;
  always_comb begin
    need = 2'd0;
    case (cmd_q)
      CmdAdd, CmdSub, CmdMul, CmdDiv, CmdAssign: need = 2'd2;
      CmdNeg, CmdRead, CmdWriteint, CmdLoad, CmdJmpz: need = 2'd1;
      default: need = 2'd0;
    endcase
  end

  logic [PcBits-1:0] pc1, pc2;
  assign pc1 = pc_q + PcBits'(1);
  assign pc2 = pc_q + PcBits'(2);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      err_e                e;
      kind_e               k;
      logic [WordBits-1:0] v, r;
      logic [PcBits-1:0]   nx;
      logic [SpBits-1:0]   n;
      logic                swe, dwe, h, ud;
      logic [SaBits-1:0]   swa;
      logic [DaBits-1:0]   wa;
      logic [WordBits-1:0] wd;
      e = ErrNone; k = KindNone; v = '0; r = '0; nx = pc1; n = sp_q;
      swe = 1'b0; dwe = 1'b0; h = 1'b0; ud = 1'b0; swa = ra_s;
      wa = t_q[DaBits-1:0];
      wd = opw_q;
      if (halted_q) begin
        k = KindHalted; nx = pc_q;
      end else if (cmd_q == CmdBad14 || cmd_q == CmdBad15) begin
        e = ErrUnknown;
      end else if (sp_q < SpBits'(need) ||
                   (cmd_q == CmdPush && sp_q >= SpBits'(StackDepth))) begin
        e = ErrStack;
      end else begin
        case (cmd_q)
          CmdAdd: begin r = s_q + t_q; swe = 1'b1; n = sp_q - 1'b1; end
          CmdSub: begin r = s_q - t_q; swe = 1'b1; n = sp_q - 1'b1; end
          CmdMul: begin r = s_q * t_q; swe = 1'b1; n = sp_q - 1'b1; end
          CmdDiv: begin
            if (t_q == '0) e = ErrDivZero;
            else begin ud = 1'b1; swe = 1'b1; n = sp_q - 1'b1; end
          end
          CmdNeg: begin r = -t_q; swe = 1'b1; swa = ra_t; end
          CmdAssign: begin
            if (!addr_ok(s_q, DataWords)) e = ErrAddr;
            else begin
              dwe = 1'b1; n = sp_q - SpBits'(2);
              wa = s_q[DaBits-1:0];
              wd = t_q;
            end
          end
          CmdRead: begin
            if (!addr_ok(t_q, DataWords)) e = ErrAddr;
            else begin dwe = 1'b1; n = sp_q - 1'b1; end
          end
          CmdNewline: k = KindNewline;
          CmdWriteint: begin k = KindInt; v = t_q; n = sp_q - 1'b1; end
          CmdPush: begin
            r = opw_q; swe = 1'b1; swa = SaBits'(sp_q); n = sp_q + 1'b1; nx = pc2;
          end
          CmdLoad: begin
            if (!addr_ok(t_q, DataWords)) e = ErrAddr;
            else begin r = dm_q; swe = 1'b1; swa = ra_t; end
          end
          CmdJmp: begin
            if (!addr_ok(opw_q, ProgramWords)) e = ErrAddr;
            else nx = opw_q[PcBits-1:0];
          end
          CmdJmpz: begin
            if (t_q == '0) begin
              if (!addr_ok(opw_q, ProgramWords)) e = ErrAddr;
              else nx = opw_q[PcBits-1:0];
            end else nx = pc2;
            n = sp_q - 1'b1;
          end
          default: begin h = 1'b1; k = KindHalted; nx = pc_q; end
        endcase
      end
      if (e != ErrNone) begin
        h = 1'b1; k = KindError; v = '0; nx = pc_q; n = sp_q;
        swe = 1'b0; dwe = 1'b0; ud = 1'b0;
      end
      err_q <= e; kind_q <= k; val_q <= v; res_q <= r; pcn_q <= nx; spn_q <= n;
      stk_we_q <= swe; dat_we_q <= dwe; halt_d_q <= h | halted_q; use_div_q <= ud;
      stk_wa_q <= swa;
      dat_wa_q <= wa;
      dat_wd_q <= wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      sp_q     <= '0;
      halted_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      pc_q     <= pcn_q;
      sp_q     <= spn_q;
      halted_q <= halt_d_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      npc_o_q <= PcOutBits'(pcn_q);
      okind_q <= kind_q;
      oerr_q  <= err_q;
      oval_q  <= OpBits'(val_q);
    end
  end

  // divider: done is delayed through div_wait_q and div_fin_q so the final quotient bit is folded in and registered
  logic div_fin_q, div_wait_q;
  logic [WordBits-1:0] div_q_q;
  logic [WordBits-1:0] quo_raw;
  sbe_div #(.WordBits(WordBits)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl_i.div_start),
    .num_i  (s_q),
    .den_i  (t_q),
    .done_o (div_done),
    .quo_o  (quo_raw)
  );
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_fin_q  <= 1'b0;
      div_wait_q <= 1'b0;
    end else begin
      div_wait_q <= div_done;
      div_fin_q  <= div_wait_q;
    end
  end
  always_ff @(posedge clk_i) div_q_q <= quo_raw;
  assign div_quo = div_q_q;

  assign stat_o.need_div = (cmd_q == CmdDiv) && !halted_q && (sp_q >= SpBits'(2)) &&
                           (t_q != '0);
  assign stat_o.div_done = div_fin_q;
  assign stat_o.ready    = wipe_done;

  assign next_pc_o    = npc_o_q;
  assign out_kind_o   = okind_q;
  assign out_value_o  = oval_q;
  assign error_code_o = oerr_q;
endmodule
`default_nettype wire

// ----- rtl/stack_bytecode_executor.sv -----
`default_nettype none
// Stack bytecode executor: each input transaction carries one decoded
// instruction (command and operand); each produces exactly one result
// transaction with the next program counter, an output kind, the written
// integer and an error code. An ordinary instruction passes through
// capture, stack read, data-memory read, execute and commit, set by the
// registered stack read followed by the registered data-memory read; the
// next instruction is accepted only after the previous one has committed,
// and commit waits while an undelivered result is stalled. A divide adds
// the bit-serial divider between execute and commit. After reset the data
// memory is cleared by a sweep, during which the input is stalled.
module stack_bytecode_executor #(
  parameter int unsigned STACK_DEPTH   = sbe_pkg::StackDepthDef,
  parameter int unsigned DATA_WORDS    = sbe_pkg::DataWordsDef,
  parameter int unsigned PROGRAM_WORDS = sbe_pkg::ProgramWordsDef,
  parameter int unsigned WORD_BITS     = sbe_pkg::WordBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [sbe_pkg::CmdBits-1:0]       command_i,
  input  wire logic signed [sbe_pkg::OpBits-1:0] operand_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [sbe_pkg::PcOutBits-1:0]          next_pc_o,
  output logic [sbe_pkg::KindBits-1:0]           out_kind_o,
  output logic signed [sbe_pkg::OpBits-1:0]      out_value_o,
  output logic [sbe_pkg::ErrBits-1:0]            error_code_o
);
  import sbe_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  sbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  sbe_dpath #(
    .StackDepth  (STACK_DEPTH),
    .DataWords   (DATA_WORDS),
    .ProgramWords(PROGRAM_WORDS),
    .WordBits    (WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .command_i   (command_i),
    .operand_i   (operand_i),
    .next_pc_o   (next_pc_o),
    .out_kind_o  (out_kind_o),
    .out_value_o (out_value_o),
    .error_code_o(error_code_o)
  );
endmodule
`default_nettype wire

// ----- rtl/sbe_checker.sv -----
`default_nettype none
module sbe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  out_kind_o,
  input wire logic [2:0]  error_code_o,
  input wire logic [31:0] out_value_o
);
  import sbe_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o))
    else $error("result changed under stall");
  // error code only on error halt
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KindError |-> error_code_o == ErrNone)
    else $error("stray error code");
  // value only with writeint
  a_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KindInt |-> out_value_o == 32'd0)
    else $error("stray output value");
  // one instruction in flight
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted");
endmodule

bind stack_bytecode_executor sbe_checker u_sbe_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_kind_o(out_kind_o),
  .error_code_o(error_code_o), .out_value_o(out_value_o)
);
`default_nettype wire
